FILE: src/ssd_pkg.sv
// Package with the payload types, sequencer states and divider step of the section descriptor.
package ssd_pkg;

    typedef struct packed {
        logic [30:0] sec_lb;
        logic [30:0] sec_ub;
        logic        ub_open;
        logic [30:0] sec_stride;
        logic [30:0] global_size;
        logic [30:0] local_lb;
        logic [30:0] local_size;
        logic [31:0] distance;
        logic        last_dim;
    } dim_t;

    typedef struct packed {
        logic        is_section_dim;
        logic [2:0]  section_index;
        logic [30:0] section_size;
        logic [31:0] section_distance;
        logic [31:0] start_offset;
        logic        overflow;
        logic        last_out;
    } res_t;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DIV_UB   = 7'b0000010,
        S_DIV_LB   = 7'b0000100,
        S_DIV_SPAN = 7'b0001000,
        S_MUL_OFS  = 7'b0010000,
        S_MUL_DIST = 7'b0100000,
        S_SUM      = 7'b1000000
    } ssd_state_t;

    localparam int DivCycles = 16;
    localparam int DivCntW = $clog2(DivCycles);

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
    } div_state_t;

    // One restoring division step: shift one dividend bit into the remainder.
    function automatic div_state_t div_step(div_state_t st, logic [30:0] dvs);
        logic [31:0] shifted;
        logic [32:0] trial;
        div_state_t  r;
        shifted = {st.rem[30:0], st.quo[31]};
        trial = {1'b0, shifted} - {2'b00, dvs};
        r.rem = trial[32] ? shifted : trial[31:0];
        r.quo = {st.quo[30:0], ~trial[32]};
        return r;
    endfunction

endpackage

FILE: src/ssd_stream_if.sv
// Valid/ready channel interface carrying one payload per transaction.
interface ssd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/strided_section_descriptor.sv
// Top level of the strided section descriptor builder with its shared divider and multiplier.
//
//  channel | modport | payload          | meaning
//  dim     | sink    | ssd_pkg::dim_t   | one grid dimension per transaction
//  res     | source  | ssd_pkg::res_t   | one descriptor entry per transaction
//
// An accepted dimension is processed to the end before the next one can be accepted:
// three divisions by the stride on one shared radix-4 divider, two passes through
// the shared 32x32 multiplier and one saturating add.
// The result waits in an output register, so a stalled sink only holds the final add
// once the register is still full. Reset clears the offset, count and overflow flag.
module strided_section_descriptor #(
    parameter int MAX_DIMS = 8
) (
    input  logic clk,
    input  logic rst_n,
    ssd_stream_if.sink   dim,
    ssd_stream_if.source res
);

    localparam logic [2:0] LastIdx = 3'(MAX_DIMS - 1);

    ssd_pkg::ssd_state_t state_reg, state_next;

    logic [30:0] lb_reg, ub_reg, s_reg, loc_lb_reg;
    logic [31:0] loc_hi_reg, dist_reg;
    logic        range_reg, last_reg;

    logic [31:0] rem_reg, quo_reg;
    logic [ssd_pkg::DivCntW-1:0] cnt_reg;
    logic [31:0] high_reg, l0_reg;
    logic [30:0] size_reg;
    logic [63:0] mul_reg, ofs_prod_reg;

    logic [31:0] offset_acc_reg;
    logic [2:0]  section_count_reg;
    logic        overflow_seen_reg;

    logic          out_valid_reg;
    ssd_pkg::res_t out_data_reg;

    ssd_pkg::div_state_t div_cur, div_mid, div_nx;
    logic        div_last;
    logic [30:0] ub_sel, s_sel;
    logic [30:0] high_clip;
    logic [31:0] high_n, l0_n;
    logic        slot_free;
    logic        prod_sat, sum_sat, sd_sat;
    logic [31:0] prod32, sum32, sdist32;
    logic [32:0] sum33;
    logic [31:0] mul_a;
    logic [63:0] mul_full;

    assign dim.ready = (state_reg == ssd_pkg::S_IDLE);
    assign res.valid = out_valid_reg;
    assign res.data = out_data_reg;

    assign ub_sel = dim.data.ub_open ? dim.data.global_size : dim.data.sec_ub;
    assign s_sel = (dim.data.sec_stride == 31'd0) ? 31'd1 : dim.data.sec_stride;

    assign div_cur = '{rem: rem_reg, quo: quo_reg};
    assign div_mid = ssd_pkg::div_step(div_cur, s_reg);
    assign div_nx = ssd_pkg::div_step(div_mid, s_reg);
    assign div_last = (cnt_reg == ssd_pkg::DivCntW'(ssd_pkg::DivCycles - 1));

    assign high_clip = (lb_reg >= ub_reg) ? ub_reg : ub_reg - div_nx.rem[30:0];
    assign high_n = ({1'b0, high_clip} < loc_hi_reg) ? {1'b0, high_clip} : loc_hi_reg;
    assign l0_n = (lb_reg < loc_lb_reg)
        ? {1'b0, loc_lb_reg} - 32'd1 - div_nx.rem + {1'b0, s_reg}
        : {1'b0, lb_reg};

    assign slot_free = !out_valid_reg || res.ready;

    assign mul_a = (state_reg == ssd_pkg::S_MUL_OFS) ? l0_reg : {1'b0, s_reg};
    assign mul_full = {32'd0, mul_a} * {32'd0, dist_reg};

    assign prod_sat = |ofs_prod_reg[63:32];
    assign prod32 = prod_sat ? '1 : ofs_prod_reg[31:0];
    assign sum33 = {1'b0, offset_acc_reg} + {1'b0, prod32};
    assign sum_sat = sum33[32];
    assign sum32 = sum_sat ? '1 : sum33[31:0];
    assign sd_sat = |mul_reg[63:32];
    assign sdist32 = range_reg ? (sd_sat ? '1 : mul_reg[31:0]) : 32'd0;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ssd_pkg::S_IDLE:
            begin
                if (dim.valid)
                begin
                    state_next = ssd_pkg::S_DIV_UB;
                end
            end
            ssd_pkg::S_DIV_UB:
            begin
                if (div_last)
                begin
                    state_next = ssd_pkg::S_DIV_LB;
                end
            end
            ssd_pkg::S_DIV_LB:
            begin
                if (div_last)
                begin
                    state_next = ssd_pkg::S_DIV_SPAN;
                end
            end
            ssd_pkg::S_DIV_SPAN:
            begin
                if (div_last)
                begin
                    state_next = ssd_pkg::S_MUL_OFS;
                end
            end
            ssd_pkg::S_MUL_OFS:  state_next = ssd_pkg::S_MUL_DIST;
            ssd_pkg::S_MUL_DIST: state_next = ssd_pkg::S_SUM;
            ssd_pkg::S_SUM:
            begin
                if (slot_free)
                begin
                    state_next = ssd_pkg::S_IDLE;
                end
            end
            default: state_next = ssd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssd_pkg::S_IDLE;
            cnt_reg <= '0;
            offset_acc_reg <= '0;
            section_count_reg <= '0;
            overflow_seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ssd_pkg::S_DIV_UB || state_reg == ssd_pkg::S_DIV_LB
                || state_reg == ssd_pkg::S_DIV_SPAN)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
            if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ssd_pkg::S_SUM && slot_free)
            begin
                out_valid_reg <= 1'b1;
                if (last_reg)
                begin
                    offset_acc_reg <= '0;
                    section_count_reg <= '0;
                    overflow_seen_reg <= 1'b0;
                end
                else
                begin
                    offset_acc_reg <= sum32;
                    overflow_seen_reg <= overflow_seen_reg | prod_sat | sum_sat
                        | (range_reg & sd_sat);
                    if (range_reg && section_count_reg < LastIdx)
                    begin
                        section_count_reg <= section_count_reg + 3'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ssd_pkg::S_IDLE:
            begin
                if (dim.valid)
                begin
                    lb_reg <= dim.data.sec_lb;
                    ub_reg <= ub_sel;
                    s_reg <= s_sel;
                    range_reg <= (dim.data.sec_stride != 31'd0);
                    loc_lb_reg <= dim.data.local_lb;
                    loc_hi_reg <= {1'b0, dim.data.local_lb} + {1'b0, dim.data.local_size};
                    dist_reg <= dim.data.distance;
                    last_reg <= dim.data.last_dim;
                    rem_reg <= '0;
                    quo_reg <= {1'b0, ub_sel - dim.data.sec_lb - 31'd1};
                end
            end
            ssd_pkg::S_DIV_UB:
            begin
                if (div_last)
                begin
                    high_reg <= high_n;
                    rem_reg <= '0;
                    quo_reg <= {1'b0, loc_lb_reg - lb_reg - 31'd1};
                end
                else
                begin
                    rem_reg <= div_nx.rem;
                    quo_reg <= div_nx.quo;
                end
            end
            ssd_pkg::S_DIV_LB:
            begin
                if (div_last)
                begin
                    l0_reg <= l0_n;
                    rem_reg <= '0;
                    quo_reg <= high_reg - l0_n - 32'd1;
                end
                else
                begin
                    rem_reg <= div_nx.rem;
                    quo_reg <= div_nx.quo;
                end
            end
            ssd_pkg::S_DIV_SPAN:
            begin
                rem_reg <= div_nx.rem;
                quo_reg <= div_nx.quo;
                if (div_last)
                begin
                    // The span is quotient * stride + 1, so the count is quotient + 1.
                    size_reg <= (range_reg && l0_reg < high_reg)
                        ? div_nx.quo[30:0] + 31'd1 : 31'd0;
                    l0_reg <= l0_reg - {1'b0, loc_lb_reg};
                end
            end
            ssd_pkg::S_MUL_OFS:
            begin
                mul_reg <= mul_full;
            end
            ssd_pkg::S_MUL_DIST:
            begin
                ofs_prod_reg <= mul_reg;
                mul_reg <= mul_full;
            end
            ssd_pkg::S_SUM:
            begin
                if (slot_free)
                begin
                    out_data_reg.is_section_dim <= range_reg;
                    out_data_reg.section_index <= range_reg ? section_count_reg : 3'd0;
                    out_data_reg.section_size <= size_reg;
                    out_data_reg.section_distance <= sdist32;
                    out_data_reg.start_offset <= sum32;
                    out_data_reg.overflow <= overflow_seen_reg | prod_sat | sum_sat
                        | (range_reg & sd_sat);
                    out_data_reg.last_out <= last_reg;
                end
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        section_count_reg <= LastIdx)
        else $error("Section dimension count passed its limit.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssd_pkg::S_SUM && slot_free && last_reg)
        |=> (offset_acc_reg == 32'd0 && section_count_reg == 3'd0 && !overflow_seen_reg))
        else $error("Accumulators not cleared after the last dimension.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.data.is_section_dim)
        |-> (res.data.section_size == 31'd0 && res.data.section_index == 3'd0
             && res.data.section_distance == 32'd0))
        else $error("Fixed index dimension reports section fields.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssd_pkg::S_IDLE) |-> (cnt_reg == '0))
        else $error("Divider counter running while idle.");

endmodule

FILE: test/ssd_checker.sv
// Checker that predicts every descriptor entry of the section descriptor and compares it.
module ssd_checker #(
    parameter int MAX_DIMS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          dim_valid,
    input  logic          dim_ready,
    input  ssd_pkg::dim_t dim_data,
    input  logic          res_valid,
    input  logic          res_ready,
    input  ssd_pkg::res_t res_data,
    output int            errors,
    output int            pending
);

    logic [31:0]   offset_sum;
    logic [2:0]    dim_count;
    logic          sat_seen;
    ssd_pkg::res_t entry_queue[$];

    function automatic logic [63:0] lattice_end(logic [63:0] lo, logic [63:0] hi,
                                                logic [63:0] s);
        if (lo >= hi)
        begin
            return hi;
        end
        return lo + ((hi - lo - 64'd1) / s) * s + 64'd1;
    endfunction

    function automatic logic [63:0] lattice_start(logic [63:0] lo, logic [63:0] floor_v,
                                                  logic [63:0] s);
        if (lo < floor_v)
        begin
            return lo + ((floor_v - lo - 64'd1) / s + 64'd1) * s;
        end
        return lo;
    endfunction

    function automatic logic [63:0] clamp32(logic [63:0] v);
        if (v > 64'hFFFF_FFFF)
        begin
            sat_seen = 1'b1;
            return 64'hFFFF_FFFF;
        end
        return v;
    endfunction

    function automatic ssd_pkg::res_t build_entry(ssd_pkg::dim_t d);
        logic [63:0]   lo;
        logic [63:0]   hi;
        logic [63:0]   s;
        logic [63:0]   own_lo;
        logic [63:0]   own_hi;
        logic [63:0]   elem_dist;
        logic [63:0]   top;
        logic [63:0]   l0;
        logic [63:0]   l1;
        logic [63:0]   prod;
        logic [63:0]   total;
        ssd_pkg::res_t r;
        lo = {33'd0, d.sec_lb};
        hi = d.ub_open ? {33'd0, d.global_size} : {33'd0, d.sec_ub};
        s = (d.sec_stride != '0) ? {33'd0, d.sec_stride} : 64'd1;
        own_lo = {33'd0, d.local_lb};
        own_hi = own_lo + {33'd0, d.local_size};
        elem_dist = {32'd0, d.distance};
        top = lattice_end(lo, hi, s);
        if (own_hi < top)
        begin
            top = own_hi;
        end
        l0 = lattice_start(lo, own_lo, s);
        l1 = lattice_end(l0, top, s);
        if (l1 > l0)
        begin
            l0 = l0 - own_lo;
            l1 = l1 - own_lo;
        end
        else
        begin
            l0 = l0 - own_lo;
            l1 = l0;
        end
        prod = clamp32(l0 * elem_dist);
        total = clamp32({32'd0, offset_sum} + prod);
        offset_sum = total[31:0];
        r = '0;
        if (d.sec_stride != '0)
        begin
            r.is_section_dim = 1'b1;
            r.section_index = dim_count;
            r.section_size = 31'(((l1 - l0) + s - 64'd1) / s);
            r.section_distance = 32'(clamp32(elem_dist * s));
            if (dim_count < 3'(MAX_DIMS - 1))
            begin
                dim_count = dim_count + 3'd1;
            end
        end
        r.start_offset = offset_sum;
        r.overflow = sat_seen;
        r.last_out = d.last_dim;
        if (d.last_dim)
        begin
            offset_sum = '0;
            dim_count = '0;
            sat_seen = 1'b0;
        end
        return r;
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : watch
        ssd_pkg::res_t want;
        if (!rst_n)
        begin
            offset_sum = '0;
            dim_count = '0;
            sat_seen = 1'b0;
            entry_queue.delete();
            errors = 0;
        end
        else
        begin
            if (dim_valid && dim_ready)
            begin
                entry_queue.push_back(build_entry(dim_data));
            end
            if (res_valid && res_ready)
            begin
                if (entry_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result transaction, expected none, actual 0x%0h",
                             $time, res_data);
                end
                else
                begin
                    want = entry_queue.pop_front();
                    check_field("is_section_dim", 32'(want.is_section_dim),
                                32'(res_data.is_section_dim));
                    check_field("section_index", 32'(want.section_index),
                                32'(res_data.section_index));
                    check_field("section_size", 32'(want.section_size),
                                32'(res_data.section_size));
                    check_field("section_distance", want.section_distance,
                                res_data.section_distance);
                    check_field("start_offset", want.start_offset, res_data.start_offset);
                    check_field("overflow", 32'(want.overflow), 32'(res_data.overflow));
                    check_field("last_out", 32'(want.last_out), 32'(res_data.last_out));
                end
            end
        end
        pending = entry_queue.size();
    end

endmodule

FILE: test/testbench.sv
// Top of the section descriptor testbench: clock, reset, dimension stimulus and verdict.
module testbench;

    localparam int unsigned M31 = 32'h7FFF_FFFF;
    localparam int RandomItems = 1150;

    logic clk;
    logic rst_n;
    int   sent;
    int   errors;
    int   pending;
    logic quiet;

    ssd_stream_if #(.payload_t(ssd_pkg::dim_t)) dim_ch ();
    ssd_stream_if #(.payload_t(ssd_pkg::res_t)) res_ch ();

    strided_section_descriptor #(
        .MAX_DIMS(8)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .dim  (dim_ch),
        .res  (res_ch)
    );

    ssd_checker #(
        .MAX_DIMS(8)
    ) i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .dim_valid(dim_ch.valid),
        .dim_ready(dim_ch.ready),
        .dim_data (dim_ch.data),
        .res_valid(res_ch.valid),
        .res_ready(res_ch.ready),
        .res_data (res_ch.data),
        .errors   (errors),
        .pending  (pending)
    );

    assign quiet = (sent >= 500) && (sent < 700);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic ssd_pkg::dim_t make_dim(int unsigned lb, int unsigned ub, logic open,
                                               int unsigned stride, int unsigned gsz,
                                               int unsigned llb, int unsigned lsz,
                                               logic [31:0] elem_dist, logic last);
        ssd_pkg::dim_t d;
        d.sec_lb = 31'(lb);
        d.sec_ub = 31'(ub);
        d.ub_open = open;
        d.sec_stride = 31'(stride);
        d.global_size = 31'(gsz);
        d.local_lb = 31'(llb);
        d.local_size = 31'(lsz);
        d.distance = elem_dist;
        d.last_dim = last;
        return d;
    endfunction

    function automatic ssd_pkg::dim_t shaped_dim(logic last);
        int unsigned gsz;
        int unsigned llb;
        int unsigned lsz;
        int unsigned lb;
        int unsigned ub;
        int unsigned stride;
        int unsigned r;
        logic [31:0] elem_dist;
        gsz = ($urandom_range(9) < 7) ? $urandom_range(1, 300) : $urandom_range(1, M31);
        llb = $urandom_range(0, gsz - 1);
        lsz = $urandom_range(0, gsz - llb);
        lb = $urandom_range(0, gsz);
        ub = $urandom_range(lb, gsz);
        r = $urandom_range(9);
        if (r < 2)
            stride = 0;
        else if (r < 7)
            stride = $urandom_range(1, 4);
        else if (r < 9)
            stride = $urandom_range(1, 64);
        else
            stride = $urandom_range(1, M31);
        r = $urandom_range(9);
        if (r < 6)
            elem_dist = $urandom_range(0, 1000);
        else if (r < 9)
            elem_dist = $urandom_range(0, 65535);
        else
            elem_dist = $urandom;
        return make_dim(lb, ub, ($urandom_range(3) == 0), stride, gsz, llb, lsz, elem_dist,
                        last);
    endfunction

    function automatic ssd_pkg::dim_t noise_dim(logic last);
        return make_dim($urandom, $urandom, 1'($urandom), $urandom, $urandom, $urandom,
                        $urandom, $urandom, last);
    endfunction

    task automatic send_dim(ssd_pkg::dim_t d);
        while (!quiet && ($urandom_range(99) < 8))
        begin
            dim_ch.valid <= 1'b0;
            @(posedge clk);
        end
        dim_ch.valid <= 1'b1;
        dim_ch.data <= d;
        @(posedge clk);
        while (!dim_ch.ready)
        begin
            @(posedge clk);
        end
        sent++;
    endtask

    initial
    begin : result_sink
        int hold;
        bit held;
        hold = 0;
        held = 1'b0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && (sent >= 150))
            begin
                held = 1'b1;
                hold = 1500;
            end
            if (hold > 0)
            begin
                hold--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= quiet || ($urandom_range(99) >= 8);
            end
        end
    end

    initial
    begin : stimulus
        int   ndims;
        int   target;
        bit   noisy;
        logic last;
        sent = 0;
        rst_n <= 1'b0;
        dim_ch.valid <= 1'b0;
        dim_ch.data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_dim(make_dim(0, 0, 1'b0, 0, 0, 0, 0, 32'd0, 1'b1));
        send_dim(make_dim(M31, M31, 1'b1, M31, M31, M31, M31, 32'hFFFF_FFFF, 1'b1));
        send_dim(make_dim(2, 20, 1'b0, 3, 32, 8, 8, 32'd4, 1'b0));
        send_dim(make_dim(13, 14, 1'b0, 0, 32, 8, 8, 32'd100, 1'b0));
        send_dim(make_dim(1, 0, 1'b1, 2, 50, 0, 50, 32'd1000, 1'b1));
        send_dim(make_dim(40, 60, 1'b0, 1, 100, 0, 10, 32'd3, 1'b0));
        send_dim(make_dim(0, 5, 1'b0, 1, 100, 10, 10, 32'd7, 1'b1));
        send_dim(make_dim(2, 3, 1'b0, 0, 100, 10, 10, 32'd9, 1'b1));
        send_dim(make_dim(32'h7FFF_FFF0, M31, 1'b0, 1, M31, 0, M31, 32'hFFFF_FFFF, 1'b0));
        send_dim(make_dim(0, M31, 1'b0, 32'h4000_0000, M31, 0, M31, 32'h10, 1'b1));
        send_dim(make_dim(32'h7FFF_0000, M31, 1'b0, 0, M31, 0, M31, 32'd2, 1'b0));
        send_dim(make_dim(32'h7FFF_0000, M31, 1'b0, 0, M31, 0, M31, 32'd2, 1'b1));
        for (int k = 0; k < 10; k++)
        begin
            send_dim(make_dim(k, 40, 1'b0, 1 + k % 3, 64, 4, 30, 32'(k + 1), (k == 9)));
        end

        target = sent + RandomItems;
        while (sent < target)
        begin
            ndims = $urandom_range(1, 10);
            noisy = ($urandom_range(99) < 15);
            for (int k = 0; k < ndims; k++)
            begin
                last = (k == ndims - 1);
                if (noisy)
                    send_dim(noise_dim(last ^ ($urandom_range(9) == 0)));
                else
                    send_dim(shaped_dim(last));
            end
        end
        dim_ch.valid <= 1'b0;

        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
        if ((errors == 0) && (pending == 0))
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
src/ssd_pkg.sv
src/ssd_stream_if.sv
src/strided_section_descriptor.sv
test/ssd_checker.sv
test/testbench.sv
